/* sv/lidar_packet_point_decoder_macros.svh */
// Assertion macros shared by the decoder modules
`ifndef LIDAR_PACKET_POINT_DECODER_MACROS_SVH
`define LIDAR_PACKET_POINT_DECODER_MACROS_SVH

// Implication checked at every clock edge outside reset
`define LPPD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define LPPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/lppd_pkg.sv */
`default_nettype none
package lppd_pkg;
	localparam logic [7:0]  HDR_BYTE0   = 8'hA5;
	localparam logic [7:0]  HDR_BYTE1   = 8'h5A;
	localparam logic [21:0] RPM_NUMER   = 22'd2500000;
	localparam logic [16:0] FULL_TURN   = 17'd36000;
	localparam logic [10:0] PACKET_SPAN = 11'd1500;
	localparam logic [10:0] SCAN_V1     = 11'd1008;
	localparam logic [10:0] SCAN_V2     = 11'd1680;
	localparam logic [7:0]  PTS_V1      = 8'd42;
	localparam logic [7:0]  PTS_V2      = 8'd70;
	localparam logic [1:0]  REG_LAYOUT  = 2'd0;
	localparam logic [1:0]  REG_MIN     = 2'd1;
	localparam logic [1:0]  REG_MAX     = 2'd2;

	// Controller states
	typedef enum logic [6:0] {
		ST_RECV  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_READ  = 7'b0000100,
		ST_ANG   = 7'b0001000,
		ST_SLOT  = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_CLOSE = 7'b1000000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;     // byte taken this cycle
		logic start;      // packet closed with good header
		logic div_step;   // one step of the shared divider
		logic rd;         // issue a store read
		logic ang_start;  // start angle division
		logic slot_load;  // latch slot (second when slot_sel)
		logic slot_sel;
		logic out_load;   // move assembled result to output register
		logic idx_inc;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic good_end;   // final byte of packet with good header
		logic div_done;
		logic idx_valid;  // current point index below count
		logic pair_last;  // this result is the packet's last
	} sts_t;
endpackage
`default_nettype wire

/* sv/lidar_packet_point_decoder.sv */
`default_nettype none
// Lidar packet point decoder. Takes one packet byte per cycle while receiving;
// after the final byte of a packet with a good A5 5A header it leaves intake
// for a closing state and a 22-step bit-serial rpm division, then handles each
// point with a store read, a 23-step angle division on the shared divider and
// a slot load, and emits points two per output transaction, holding while the
// output is stalled. Intake resumes the cycle after the last transaction of
// the packet is loaded. Packets with a bad header give no output and never
// leave intake.
module lidar_packet_point_decoder
	import lppd_pkg::*;
#(
	parameter int MAX_PACKET_POINTS = 70
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tlast,  // packet_end
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// first_range, first_strong, first_angle, first_present, second_range,
	// second_strong, second_angle, second_present, motor_rpm, rpm_present,
	// scan_complete, zero fill
	output logic [95:0]      m_axis_tdata,
	output logic             m_axis_tlast,  // last
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic [90:0] od;

	lppd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
		.out_tready(m_axis_tready), .out_tvalid(m_axis_tvalid), .sts(sts), .cmd(cmd)
	);

	lppd_dp #(.MAX_PACKET_POINTS(MAX_PACKET_POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .data_byte(s_axis_tdata),
		.packet_end(s_axis_tlast), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .out_data(od)
	);

	assign m_axis_tdata = {6'd0, od[89:0]};
	assign m_axis_tlast = od[90];
endmodule
`default_nettype wire

/* sv/lppd_ram.sv */
`default_nettype none
module lppd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 70
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* sv/lppd_ctrl.sv */
`default_nettype none
module lppd_ctrl
	import lppd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_tvalid,
	output logic      in_tready,
	input  wire logic out_tready,
	output logic      out_tvalid,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	`include "lidar_packet_point_decoder_macros.svh"

	state_t state_q, state_d;
	logic   valid_q;
	logic   half_q;   // 0: filling first slot, 1: second

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_tready = (state_q == ST_RECV);
		cmd.accept = in_tready && in_tvalid;
		cmd.slot_sel = half_q;
		case (state_q)
			ST_RECV: begin
				if (cmd.accept && sts.good_end) state_d = ST_CLOSE;
			end
			// final byte has settled into the packet fields
			ST_CLOSE: begin
				cmd.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_READ;
			end
			ST_READ: begin
				// wait until output register is free before starting a new pair
				if (!half_q && valid_q && !out_tready) state_d = ST_READ;
				else if (sts.idx_valid) begin
					cmd.rd = 1'b1;
					cmd.ang_start = 1'b1;
					state_d = ST_ANG;
				end else state_d = ST_OUT;
			end
			ST_ANG: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = ST_SLOT;
			end
			ST_SLOT: begin
				cmd.slot_load = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d = half_q ? ST_OUT : ST_READ;
			end
			ST_OUT: begin
				if (!valid_q || out_tready) begin
					cmd.out_load = 1'b1;
					state_d = sts.pair_last ? ST_RECV : ST_READ;
				end
			end
			default: state_d = ST_RECV;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) valid_q <= 1'b1;
			else if (out_tready) valid_q <= 1'b0;
			if (cmd.start || cmd.out_load) half_q <= 1'b0;
			else if (cmd.slot_load) half_q <= ~half_q;
		end
	end

	assign out_tvalid = valid_q;

	`LPPD_ASSERT_IMPL(a_onehot, 1'b1, $onehot(state_q))
	`LPPD_ASSERT_IMPL(a_noacc, state_q != ST_RECV, !in_tready)
	`LPPD_ASSERT_NEXT(a_load, cmd.out_load, out_tvalid)
endmodule
`default_nettype wire

/* sv/lppd_dp.sv */
`default_nettype none
module lppd_dp
	import lppd_pkg::*;
#(
	parameter int MAX_PACKET_POINTS = 70
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [7:0]  data_byte,
	input  wire logic        packet_end,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic [90:0]      out_data
);
	localparam int AW = $clog2(MAX_PACKET_POINTS);
	localparam int CW = $clog2(MAX_PACKET_POINTS + 1);
	localparam logic [7:0] CAP_L = 8'(MAX_PACKET_POINTS);

	logic [1:0]  layout_q;
	logic [15:0] min_q, max_q;
	logic [7:0]  pos_q, low_q;
	logic        hdr_q;
	logic [15:0] start_q, period_q, prev_q;
	logic [CW-1:0] nvalid_q, idx_q;
	logic [10:0] scan_q;
	logic        complete_q;

	// Layout decode
	logic        v1;
	logic [7:0]  pts, cap, deg_off, rpm_off, dat_off, dat_end;
	logic [15:0] word;
	logic        in_area, store_we;
	assign v1      = (layout_q == 2'd1);
	assign pts     = v1 ? PTS_V1 : PTS_V2;
	assign cap     = (pts < CAP_L) ? pts : CAP_L;
	assign deg_off = v1 ? 8'd2 : 8'd4;
	assign rpm_off = v1 ? 8'd4 : 8'd6;
	assign dat_off = v1 ? 8'd6 : 8'd8;
	assign dat_end = dat_off + {pts[6:0], 1'b0};
	assign word    = {low_q, data_byte};
	assign in_area = (pos_q >= dat_off) && (pos_q < dat_end) && pos_q[0] != dat_off[0];
	assign store_we = cmd.accept && pos_q != 8'd0 && in_area && word != 16'hFFFF
		&& {{(8-CW){1'b0}}, nvalid_q} < cap;

	logic hdr_next;
	assign hdr_next = (pos_q == 8'd0) ? (data_byte == HDR_BYTE0)
		: (pos_q == 8'd1) ? (hdr_q && data_byte == HDR_BYTE1) : hdr_q;
	assign sts.good_end = packet_end && pos_q != 8'd0 && hdr_next;

	// Shared restoring divider: rpm, then each point angle offset
	logic [23:0] dnum_q;   // quotient / numerator bits
	logic [16:0] drem_q;
	logic [15:0] dden_q;
	logic [4:0]  dcnt_q;
	logic [16:0] trial;
	logic [21:0] rpm_q;
	logic        rpm_phase_q;
	assign trial = {drem_q[15:0], dnum_q[23]} - {1'b0, dden_q};
	assign sts.div_done = (dcnt_q == 5'd1);

	// Store and slot assembly
	logic [15:0] rd_word;
	logic [16:0] ang_sum, ang_w;
	logic [14:0] rng;
	logic [22:0] span_prod;
	assign span_prod = 23'(PACKET_SPAN) * 23'(idx_q);
	// angle offset is below 1500, eleven quotient bits
	assign ang_sum = {1'b0, start_q} + {6'd0, dnum_q[10:0]};
	assign ang_w   = (ang_sum > FULL_TURN) ? ang_sum - FULL_TURN : ang_sum;
	assign rng = ({1'b0, rd_word[14:0]} < min_q || {1'b0, rd_word[14:0]} > max_q)
		? 15'd0 : rd_word[14:0];
	assign sts.idx_valid = idx_q < nvalid_q;
	assign sts.pair_last = !(idx_q < nvalid_q);

	lppd_ram #(.WIDTH(16), .DEPTH(MAX_PACKET_POINTS)) u_store (
		.clk(clk), .we(store_we), .waddr(nvalid_q[AW-1:0]), .wdata(word),
		.raddr(idx_q[AW-1:0]), .rdata(rd_word)
	);

	logic [11:0] scan_sum;
	assign scan_sum = {1'b0, scan_q} + {{(12-CW){1'b0}}, nvalid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 2'd2; min_q <= 16'd300; max_q <= 16'hFFFF;
			pos_q <= '0; low_q <= '0; hdr_q <= 1'b0;
			start_q <= '0; period_q <= '0; prev_q <= '0;
			nvalid_q <= '0; idx_q <= '0; scan_q <= '0; complete_q <= 1'b0;
			dcnt_q <= '0; rpm_phase_q <= 1'b0;
			dnum_q <= '0; drem_q <= '0; dden_q <= '0; rpm_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LAYOUT: layout_q <= cfg_data[1:0];
					REG_MIN:    min_q <= cfg_data;
					REG_MAX:    max_q <= cfg_data;
					default: ;
				endcase
			end
			// Byte intake
			if (cmd.accept) begin
				hdr_q <= hdr_next;
				if (pos_q == 8'd0) begin
					start_q <= '0; period_q <= '0; nvalid_q <= '0;
				end
				if (pos_q == deg_off + 8'd1) start_q <= word;
				if (pos_q == rpm_off + 8'd1) period_q <= word;
				if (store_we) nvalid_q <= nvalid_q + 1'b1;
				low_q <= data_byte;
				pos_q <= packet_end ? 8'd0 : (pos_q == 8'd255 ? pos_q : pos_q + 8'd1);
			end
			// Packet close: scan bookkeeping and rpm division start
			if (cmd.start) begin
				complete_q <= (start_q < prev_q) || (scan_sum[10:0] >= (v1 ? SCAN_V1 : SCAN_V2));
				scan_q <= ((start_q < prev_q) || (scan_sum[10:0] >= (v1 ? SCAN_V1 : SCAN_V2)))
					? 11'd0 : scan_sum[10:0];
				prev_q <= start_q;
				idx_q <= '0;
				dnum_q <= {RPM_NUMER, 2'b00};
				drem_q <= '0;
				dden_q <= period_q;
				dcnt_q <= 5'd22;
				rpm_phase_q <= 1'b1;
			end else if (cmd.ang_start) begin
				dnum_q <= {span_prod, 1'b0};
				drem_q <= '0;
				dden_q <= {{(16-CW){1'b0}}, nvalid_q};
				dcnt_q <= 5'd23;
				rpm_phase_q <= 1'b0;
			end else if (cmd.div_step && dcnt_q != 5'd0) begin
				dcnt_q <= dcnt_q - 5'd1;
				if (!trial[16]) begin
					drem_q <= trial;
					dnum_q <= {dnum_q[22:0], 1'b1};
				end else begin
					drem_q <= {drem_q[15:0], dnum_q[23]};
					dnum_q <= {dnum_q[22:0], 1'b0};
				end
			end
			if (rpm_phase_q && sts.div_done && cmd.div_step)
				rpm_q <= (period_q == 16'd0) ? 22'd0
					: {dnum_q[20:0], ~trial[16]};
			if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		end
	end

	// Output assembly (payload only)
	logic [32:0] first_q, second_q;
	always_ff @(posedge clk) begin
		if (cmd.start) begin first_q <= '0; second_q <= '0; end
		if (cmd.slot_load && !cmd.slot_sel)
			first_q <= {1'b1, ang_w[15:0], rd_word[15], rng};
		if (cmd.slot_load && cmd.slot_sel)
			second_q <= {1'b1, ang_w[15:0], rd_word[15], rng};
		if (cmd.out_load) begin
			out_data <= {sts.pair_last, sts.pair_last && complete_q,
				period_q != 16'd0, rpm_q, second_q, first_q};
			first_q <= '0; second_q <= '0;
		end
	end

	`include "lidar_packet_point_decoder_macros.svh"
	`LPPD_ASSERT_IMPL(a_cnt, 1'b1, nvalid_q <= CW'(MAX_PACKET_POINTS))
	`LPPD_ASSERT_IMPL(a_idx, cmd.rd, idx_q < nvalid_q)
	`LPPD_ASSERT_NEXT(a_pos, cmd.accept && packet_end, pos_q == 8'd0)
endmodule
`default_nettype wire
